### rtl/core/bhq_pkg.sv
// shared types and constants of the binary min-heap queue
package bhq_pkg;

    localparam int C_CAPACITY = 64;
    localparam int C_CNT_W    = $clog2(C_CAPACITY + 1);
    localparam int C_ADDR_W   = $clog2(C_CAPACITY);
    localparam int C_SLOT_W   = C_CNT_W + 1;

    localparam logic C_OP_INSERT = 1'b0;
    localparam logic C_OP_REMOVE = 1'b1;

    localparam logic [1:0] C_ST_OK    = 2'd0;
    localparam logic [1:0] C_ST_EMPTY = 2'd1;
    localparam logic [1:0] C_ST_FULL  = 2'd2;

    typedef struct packed {
        logic               op;
        logic [31:0]        key;
        logic signed [31:0] value_first;
        logic signed [31:0] value_second;
    } t_in_beat;

    typedef struct packed {
        logic [31:0]        out_key;
        logic signed [31:0] out_value_first;
        logic signed [31:0] out_value_second;
        logic               out_valid;
        logic [C_CNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
        logic [1:0]         status;
    } t_out_beat;

    typedef struct packed {
        logic               move;
        logic               right;
        logic [C_CNT_W-1:0] next_pos;
    } t_sift_dec;

endpackage

### rtl/core/bhq_ram.sv
// generic ram, one write port, two registered read ports
module bhq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

### rtl/core/bhq_sift.sv
// compare unit: decides one step of sift-up or sift-down
module bhq_sift import bhq_pkg::*; #(
    parameter int KEY_W = 32
) (
    input  logic               i_up,
    input  logic [C_CNT_W-1:0] i_pos,
    input  logic [C_CNT_W-1:0] i_cnt,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [KEY_W-1:0]   i_a_key,
    input  logic [KEY_W-1:0]   i_b_key,
    output t_sift_dec          o_dec
);

    logic [C_SLOT_W-1:0] lc;
    logic [C_SLOT_W-1:0] rc;
    logic [C_SLOT_W-1:0] cnt_x;
    logic                take_r;
    logic                take_l;

    always_comb begin
        lc     = {i_pos, 1'b0};
        rc     = {i_pos, 1'b1};
        cnt_x  = {1'b0, i_cnt};
        // right child only when below both the moving entry and the left child
        take_r = (rc <= cnt_x) && (i_key > i_b_key) && (i_b_key < i_a_key);
        take_l = !take_r && (lc <= cnt_x) && (i_key > i_a_key);
        if (i_up) begin
            o_dec.move     = i_key < i_a_key;
            o_dec.right    = 1'b0;
            o_dec.next_pos = i_pos >> 1;
        end else begin
            o_dec.move     = take_r || take_l;
            o_dec.right    = take_r;
            o_dec.next_pos = take_r ? rc[C_CNT_W-1:0] : lc[C_CNT_W-1:0];
        end
    end

endmodule

### rtl/core/binary_min_heap_queue.sv
// binary min-heap priority queue, top level
// the entry ram has registered read ports: it returns parent or both children
// in the cycle after the address, and the compare, write-back and next read
// of one heap level share a cycle
// a new input beat is taken only in idle, after the last result went to the output register
// reset (synchronous, active low) empties the heap; the entry ram itself is never cleared
module binary_min_heap_queue import bhq_pkg::*; #(
    parameter int KEY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    // keys arrive as 32 bits, so at most 32 key bits are ever stored
    localparam int KEY_W  = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int WORD_W = KEY_W + 64;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;  // sift-up, hole moves toward root
    localparam logic [2:0] S_DLOAD = 3'd2;  // read last entry
    localparam logic [2:0] S_DLAT  = 3'd3;  // latch last entry, read root children
    localparam logic [2:0] S_DOWN  = 3'd4;  // sift-down, hole moves toward leaves
    localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output register

    function automatic logic [C_ADDR_W-1:0] f_addr(input logic [C_SLOT_W-1:0] slot);
        logic [C_SLOT_W-1:0] z;
        z = slot - C_SLOT_W'(1);
        return z[C_ADDR_W-1:0];
    endfunction

    logic [2:0]         r_state, n_state;
    logic [C_CNT_W-1:0] r_cnt, n_cnt;
    logic [C_CNT_W-1:0] r_pos, n_pos;
    logic               r_pend, n_pend;
    logic               r_is_rm, n_is_rm;
    logic [1:0]         r_status, n_status;

    // entry being sifted (held outside the ram while the hole moves)
    logic [KEY_W-1:0]   r_ekey, n_ekey;
    logic [31:0]        r_ev1, n_ev1;
    logic [31:0]        r_ev2, n_ev2;

    // copy of slot 1, so the minimum is known without a ram read
    logic [KEY_W-1:0]   r_rkey, n_rkey;
    logic [31:0]        r_rv1, n_rv1;
    logic [31:0]        r_rv2, n_rv2;

    // entry removed by a remove beat
    logic [KEY_W-1:0]   r_res_key, n_res_key;
    logic [31:0]        r_res_v1, n_res_v1;
    logic [31:0]        r_res_v2, n_res_v2;
    logic               r_res_ok, n_res_ok;

    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;
    logic               load_out;

    logic                ram_we;
    logic [C_ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [C_ADDR_W-1:0] ram_raddr_a;
    logic [C_ADDR_W-1:0] ram_raddr_b;
    logic [WORD_W-1:0]   ram_rdata_a;
    logic [WORD_W-1:0]   ram_rdata_b;
    logic [KEY_W-1:0]    a_key;
    logic [KEY_W-1:0]    b_key;
    t_sift_dec           dec;

    logic               ent_ok;
    logic [KEY_W-1:0]   ent_key;
    logic [31:0]        ent_v1;
    logic [31:0]        ent_v2;

    bhq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (C_CAPACITY),
        .ADDR_W(C_ADDR_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(ram_raddr_a),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_a(ram_rdata_a),
        .o_rdata_b(ram_rdata_b)
    );

    assign a_key = ram_rdata_a[WORD_W-1 -: KEY_W];
    assign b_key = ram_rdata_b[WORD_W-1 -: KEY_W];

    bhq_sift #(
        .KEY_W(KEY_W)
    ) u_sift (
        .i_up   (r_state == S_UP),
        .i_pos  (r_pos),
        .i_cnt  (r_cnt),
        .i_key  (r_ekey),
        .i_a_key(a_key),
        .i_b_key(b_key),
        .o_dec  (dec)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_pend    = r_pend;
        n_is_rm   = r_is_rm;
        n_status  = r_status;
        n_ekey    = r_ekey;
        n_ev1     = r_ev1;
        n_ev2     = r_ev2;
        n_rkey    = r_rkey;
        n_rv1     = r_rv1;
        n_rv2     = r_rv2;
        n_res_key = r_res_key;
        n_res_v1  = r_res_v1;
        n_res_v2  = r_res_v2;
        n_res_ok  = r_res_ok;
        load_out  = 1'b0;

        ram_we      = 1'b0;
        ram_waddr   = f_addr({1'b0, r_pos});
        ram_wdata   = {r_ekey, r_ev1, r_ev2};
        ram_raddr_a = '0;
        ram_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_is_rm  = (i_in_data.op == C_OP_REMOVE);
                    n_status = C_ST_OK;
                    n_ekey   = i_in_data.key[KEY_W-1:0];
                    n_ev1    = i_in_data.value_first;
                    n_ev2    = i_in_data.value_second;
                    if (i_in_data.op == C_OP_INSERT) begin
                        if (r_cnt == C_CNT_W'(C_CAPACITY)) begin
                            // insert on full: dropped, report current minimum
                            n_status = C_ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt   = r_cnt + C_CNT_W'(1);
                            n_pos   = r_cnt + C_CNT_W'(1);
                            n_pend  = 1'b0;
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            // remove on empty: nothing changes
                            n_status = C_ST_EMPTY;
                            n_res_ok = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            n_res_key = r_rkey;
                            n_res_v1  = r_rv1;
                            n_res_v2  = r_rv2;
                            n_res_ok  = 1'b1;
                            n_cnt     = r_cnt - C_CNT_W'(1);
                            n_state   = (r_cnt == C_CNT_W'(1)) ? S_DONE : S_DLOAD;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_pos == C_CNT_W'(1)) begin
                    // hole reached the root
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else if (!r_pend) begin
                    ram_raddr_a = f_addr({1'b0, r_pos >> 1});
                    n_pend      = 1'b1;
                end else if (dec.move) begin
                    // parent moves down into the hole
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata_a;
                    n_pos       = dec.next_pos;
                    ram_raddr_a = f_addr({1'b0, dec.next_pos >> 1});
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DLOAD: begin
                // last entry sits at slot count+1, address count
                ram_raddr_a = r_cnt[C_ADDR_W-1:0];
                n_state     = S_DLAT;
            end
            S_DLAT: begin
                n_ekey      = ram_rdata_a[WORD_W-1 -: KEY_W];
                n_ev1       = ram_rdata_a[63:32];
                n_ev2       = ram_rdata_a[31:0];
                n_pos       = C_CNT_W'(1);
                ram_raddr_a = f_addr({C_CNT_W'(1), 1'b0});
                ram_raddr_b = f_addr({C_CNT_W'(1), 1'b1});
                n_state     = S_DOWN;
            end
            S_DOWN: begin
                if (dec.move) begin
                    // chosen child moves up into the hole
                    ram_we      = 1'b1;
                    ram_wdata   = dec.right ? ram_rdata_b : ram_rdata_a;
                    n_pos       = dec.next_pos;
                    ram_raddr_a = f_addr({dec.next_pos, 1'b0});
                    ram_raddr_b = f_addr({dec.next_pos, 1'b1});
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // keep the root copy in step with every write to slot 1
        if (ram_we && (r_pos == C_CNT_W'(1))) begin
            n_rkey = ram_wdata[WORD_W-1 -: KEY_W];
            n_rv1  = ram_wdata[63:32];
            n_rv2  = ram_wdata[31:0];
        end
    end

    // result beat assembly
    always_comb begin
        ent_ok  = r_is_rm ? r_res_ok : (r_cnt != '0);
        ent_key = r_is_rm ? r_res_key : r_rkey;
        ent_v1  = r_is_rm ? r_res_v1 : r_rv1;
        ent_v2  = r_is_rm ? r_res_v2 : r_rv2;

        n_out.out_key          = ent_ok ? 32'(ent_key) : '0;
        n_out.out_value_first  = ent_ok ? ent_v1 : '0;
        n_out.out_value_second = ent_ok ? ent_v2 : '0;
        n_out.out_valid        = ent_ok;
        n_out.count            = r_cnt;
        n_out.is_empty         = (r_cnt == '0);
        n_out.is_full          = (r_cnt == C_CNT_W'(C_CAPACITY));
        n_out.status           = r_status;

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_is_rm   <= n_is_rm;
        r_status  <= n_status;
        r_ekey    <= n_ekey;
        r_ev1     <= n_ev1;
        r_ev2     <= n_ev2;
        r_rkey    <= n_rkey;
        r_rv1     <= n_rv1;
        r_rv2     <= n_rv2;
        r_res_key <= n_res_key;
        r_res_v1  <= n_res_v1;
        r_res_v2  <= n_res_v2;
        r_res_ok  <= n_res_ok;
        if (load_out) begin
            r_out <= n_out;
        end
    end

endmodule

### sim/binary_min_heap_queue_tb.sv
// self-checking testbench of the binary min-heap queue
module binary_min_heap_queue_tb import bhq_pkg::*; ();

    localparam int KEY_W = 32;
    localparam logic [31:0] KEY_MASK = {32{1'b1}} >> (32 - KEY_W);
    localparam int TOTAL_ITEMS = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet time after the last result, in which any stray beat would show up
    localparam int SETTLE_CYCLES = 24;
    localparam int PRINT_CAP = 40;

    typedef enum {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED} t_seq_kind;

    // one directed row: input beat and, where fixed is set, the typed-in result
    typedef struct {
        t_in_beat  beat;
        bit        fixed;
        t_out_beat want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_data;

    // shadow heap, root at slot 1
    logic [31:0] q_key    [1:C_CAPACITY];
    logic [31:0] q_first  [1:C_CAPACITY];
    logic [31:0] q_second [1:C_CAPACITY];
    int          q_count = 0;

    t_out_beat pending_results[$];
    t_dir_row  dir_rows[$];
    int        sent_items = 0;
    int        results_seen = 0;
    int        mismatch_count = 0;
    int        idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    binary_min_heap_queue #(
        .KEY_WIDTH(KEY_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    // ---------------------------------------------------------------
    // heap predictor
    // ---------------------------------------------------------------

    task automatic swap_slots(input int a, input int b);
        logic [31:0] k, f, s;
        k = q_key[a];
        f = q_first[a];
        s = q_second[a];
        q_key[a] = q_key[b];
        q_first[a] = q_first[b];
        q_second[a] = q_second[b];
        q_key[b] = k;
        q_first[b] = f;
        q_second[b] = s;
    endtask

    // applies one beat to the shadow heap and returns the result it should give
    task automatic heap_apply(input t_in_beat b, output t_out_beat r);
        int pos, lc, rc;
        bit sifting;
        r = '0;
        r.status = C_ST_OK;
        if (b.op == C_OP_INSERT) begin
            if (q_count >= C_CAPACITY) begin
                // full: entry dropped, minimum still reported
                r.status = C_ST_FULL;
            end else begin
                q_count++;
                pos = q_count;
                q_key[pos] = b.key & KEY_MASK;
                q_first[pos] = b.value_first;
                q_second[pos] = b.value_second;
                // move up only while strictly smaller than the parent
                while (pos > 1 && q_key[pos] < q_key[pos / 2]) begin
                    swap_slots(pos, pos / 2);
                    pos = pos / 2;
                end
            end
            if (q_count > 0) begin
                r.out_key = q_key[1];
                r.out_value_first = q_first[1];
                r.out_value_second = q_second[1];
                r.out_valid = 1'b1;
            end
        end else begin
            if (q_count == 0) begin
                // empty: nothing removed, entry fields stay zero
                r.status = C_ST_EMPTY;
            end else begin
                r.out_key = q_key[1];
                r.out_value_first = q_first[1];
                r.out_value_second = q_second[1];
                r.out_valid = 1'b1;
                q_key[1] = q_key[q_count];
                q_first[1] = q_first[q_count];
                q_second[1] = q_second[q_count];
                q_count--;
                pos = 1;
                sifting = 1'b1;
                while (sifting) begin
                    lc = 2 * pos;
                    rc = lc + 1;
                    // right child wins only when below both parent and left child
                    if (rc <= q_count && q_key[pos] > q_key[rc] && q_key[rc] < q_key[lc]) begin
                        swap_slots(pos, rc);
                        pos = rc;
                    end else if (lc <= q_count && q_key[pos] > q_key[lc]) begin
                        swap_slots(pos, lc);
                        pos = lc;
                    end else begin
                        sifting = 1'b0;
                    end
                end
            end
        end
        r.count = q_count[C_CNT_W-1:0];
        r.is_empty = (q_count == 0);
        r.is_full = (q_count == C_CAPACITY);
    endtask

    // ---------------------------------------------------------------
    // beat builders
    // ---------------------------------------------------------------

    function automatic t_in_beat in_beat(input logic op, input logic [31:0] key,
                                         input logic [31:0] vf, input logic [31:0] vs);
        t_in_beat b;
        b.op = op;
        b.key = key;
        b.value_first = vf;
        b.value_second = vs;
        return b;
    endfunction

    function automatic t_out_beat out_beat(input logic [31:0] key, input logic [31:0] vf,
                                           input logic [31:0] vs, input logic valid,
                                           input int cnt, input logic [1:0] st);
        t_out_beat r;
        r.out_key = key;
        r.out_value_first = vf;
        r.out_value_second = vs;
        r.out_valid = valid;
        r.count = cnt[C_CNT_W-1:0];
        r.is_empty = (cnt == 0);
        r.is_full = (cnt == C_CAPACITY);
        r.status = st;
        return r;
    endfunction

    // appends one directed row to the table
    task automatic add_row(input t_in_beat b, input bit fixed, input t_out_beat want);
        t_dir_row row;
        row.beat = b;
        row.fixed = fixed;
        row.want = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // random entry; narrow keys give plenty of ties, extremes hit the compare edges
    function automatic t_in_beat rand_entry(input logic op);
        logic [31:0] key;
        case ($urandom_range(0, 3))
            0: key = $urandom;
            1: key = $urandom_range(0, 15);
            2: begin
                case ($urandom_range(0, 2))
                    0: key = 32'h0000_0000;
                    1: key = 32'hFFFF_FFFF;
                    default: key = 32'h8000_0000;
                endcase
            end
            default: key = {8'($urandom_range(0, 255)), 24'h0};
        endcase
        // key-only inserts now and then
        if ($urandom_range(0, 7) == 0)
            return in_beat(op, key, 32'h0, 32'h0);
        return in_beat(op, key, $urandom, $urandom);
    endfunction

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // presents one beat, waits for the handshake, then books the expected result
    task automatic send_beat(input t_in_beat b, input bit fixed, input t_out_beat want);
        int gap;
        t_out_beat predicted;
        gap = 0;
        // no idling while items 100 to 199 go in
        if (!(sent_items >= 100 && sent_items < 200) && $urandom_range(0, 99) < 6)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        heap_apply(b, predicted);
        pending_results.insert(pending_results.size(), fixed ? want : predicted);
        sent_items++;
    endtask

    // hold off input until every booked result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin
        t_seq_kind kind;
        int round, n, extra, ins_pct;
        t_out_beat none;
        none = '0;

        // directed rows: typed-in results only where obvious at a glance
        add_row(in_beat(C_OP_REMOVE, 32'h0, 32'h0, 32'h0), 1'b1,
                out_beat(32'h0, 32'h0, 32'h0, 1'b0, 0, C_ST_EMPTY));
        add_row(in_beat(C_OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
                out_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1, C_ST_OK));
        add_row(in_beat(C_OP_REMOVE, 32'h0, 32'h0, 32'h0), 1'b1,
                out_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0, C_ST_OK));
        add_row(in_beat(C_OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                out_beat(32'h0, 32'h0, 32'h0, 1'b0, 0, C_ST_EMPTY));
        add_row(in_beat(C_OP_INSERT, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1,
                out_beat(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1, C_ST_OK));
        add_row(in_beat(C_OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                out_beat(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 2, C_ST_OK));
        // equal keys exercise the strict compares in both directions
        add_row(in_beat(C_OP_INSERT, 32'd5, 32'h0, 32'h0), 1'b0, none);
        add_row(in_beat(C_OP_INSERT, 32'd5, 32'd1, 32'd2), 1'b0, none);
        add_row(in_beat(C_OP_INSERT, 32'd5, 32'd3, 32'd4), 1'b0, none);
        add_row(in_beat(C_OP_INSERT, 32'd3, 32'hAAAA_AAAA, 32'h5555_5555), 1'b0, none);
        add_row(in_beat(C_OP_INSERT, 32'd7, 32'h5555_5555, 32'hAAAA_AAAA), 1'b0, none);
        add_row(in_beat(C_OP_INSERT, 32'h0, 32'd11, 32'd22), 1'b0, none);
        repeat (8)
            add_row(in_beat(C_OP_REMOVE, 32'h0, 32'h0, 32'h0), 1'b0, none);
        add_row(in_beat(C_OP_REMOVE, 32'h0, 32'h0, 32'h0), 1'b1,
                out_beat(32'h0, 32'h0, 32'h0, 1'b0, 0, C_ST_EMPTY));
        add_row(in_beat(C_OP_INSERT, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF), 1'b1,
                out_beat(32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 1'b1, 1, C_ST_OK));
        add_row(in_beat(C_OP_INSERT, 32'h7FFF_FFFF, 32'h0, 32'h0), 1'b1,
                out_beat(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 2, C_ST_OK));

        // reset held low at the start, then released
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);
        wait_drained();

        // random part: first a full fill and a full drain, then a mix of sequences
        round = 0;
        while (sent_items < TOTAL_ITEMS) begin
            if (round == 0)
                kind = SEQ_FILL;
            else if (round == 1)
                kind = SEQ_DRAIN;
            else begin
                case ($urandom_range(0, 7))
                    0: kind = SEQ_FILL;
                    1: kind = SEQ_DRAIN;
                    default: kind = SEQ_MIXED;
                endcase
            end
            round++;
            case (kind)
                SEQ_FILL: begin
                    while (q_count < C_CAPACITY)
                        send_beat(rand_entry(C_OP_INSERT), 1'b0, none);
                    // inserts past capacity must be dropped
                    extra = $urandom_range(1, 3);
                    repeat (extra) send_beat(rand_entry(C_OP_INSERT), 1'b0, none);
                end
                SEQ_DRAIN: begin
                    while (q_count > 0)
                        send_beat(rand_entry(C_OP_REMOVE), 1'b0, none);
                    extra = $urandom_range(1, 2);
                    repeat (extra) send_beat(rand_entry(C_OP_REMOVE), 1'b0, none);
                end
                default: begin
                    n = $urandom_range(8, 40);
                    ins_pct = $urandom_range(25, 75);
                    repeat (n)
                        send_beat(rand_entry(($urandom_range(0, 99) < ins_pct) ?
                                             C_OP_INSERT : C_OP_REMOVE), 1'b0, none);
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        // let the last results out, then watch for strays
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("binary_min_heap_queue test passed");
        else
            $display("binary_min_heap_queue test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver and checker
    // ---------------------------------------------------------------

    // ready drops at random about 6 percent of the time, never while results 200 to 299 come out
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else if (results_seen >= 200 && results_seen < 300)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 6);
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got %h want %h", results_seen, field, got,
                     want);
        mismatch_count++;
    endtask

    // values read right after the edge are the ones the edge sampled
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending, key", o_out_data.out_key, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.out_key !== want.out_key)
                    report_mismatch("out_key", o_out_data.out_key, want.out_key);
                if (o_out_data.out_value_first !== want.out_value_first)
                    report_mismatch("out_value_first", o_out_data.out_value_first,
                                    want.out_value_first);
                if (o_out_data.out_value_second !== want.out_value_second)
                    report_mismatch("out_value_second", o_out_data.out_value_second,
                                    want.out_value_second);
                if (o_out_data.out_valid !== want.out_valid)
                    report_mismatch("out_valid", 32'(o_out_data.out_valid),
                                    32'(want.out_valid));
                if (o_out_data.count !== want.count)
                    report_mismatch("count", 32'(o_out_data.count), 32'(want.count));
                if (o_out_data.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(o_out_data.is_empty),
                                    32'(want.is_empty));
                if (o_out_data.is_full !== want.is_full)
                    report_mismatch("is_full", 32'(o_out_data.is_full), 32'(want.is_full));
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
            end
            results_seen <= results_seen + 1;
        end
    end

    // watchdog: too long without any beat on either side ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("binary_min_heap_queue test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
